[rtl/lcal_pkg.sv]
// shared codes, widths and constants of the load cell calibrator
package lcal_pkg;

  localparam int CNT_W   = 16;
  localparam int KF_W    = 32;
  localparam int SCALE_W = 48;
  localparam int FORCE_W = 48;
  localparam int NORM_W  = 25;

  localparam logic [1:0] CMD_MEASURE = 2'd0;
  localparam logic [1:0] CMD_TARE    = 2'd1;
  localparam logic [1:0] CMD_SPAN    = 2'd2;
  localparam logic [1:0] CMD_RESET   = 2'd3;

  // gather kind uses the command codes, plus this one for nothing gathered
  localparam logic [1:0] KIND_NONE = 2'd0;

  localparam logic [1:0] ST_UNCAL = 2'd0;
  localparam logic [1:0] ST_TARED = 2'd1;
  localparam logic [1:0] ST_CALIB = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MORE     = 2'd1;
  localparam logic [1:0] STAT_NOT_TARE = 2'd2;
  localparam logic [1:0] STAT_ZERO     = 2'd3;

  localparam logic REG_AVERAGE_COUNT = 1'b0;
  localparam logic REG_KNOWN_FORCE   = 1'b1;

  localparam logic [SCALE_W-1:0] SCALE_ONE = 48'h0001_0000_0000;
  localparam logic [SCALE_W-1:0] MAX48     = 48'h7FFF_FFFF_FFFF;
  localparam int                 NORM_LIM  = 16777215;

endpackage

[rtl/load_cell_tare_span_calibrator.sv]
// top level of the load cell tare and span calibrator
// Multi-channel load cell calibrator. Each input beat carries a command (measure, tare sample,
// span sample, reset calibration), a channel and a signed converter sample, and yields one
// result beat: sample minus the channel's offset, that value times the channel's scale as a
// saturated Q32.16 force, the channel's calibration state after the beat and a status code.
// All per-channel state (offset, scale, state, gather kind, running sum, sample count) sits
// in one record memory with a registered read; an item is read, modified and written back
// before the next item is taken, so accesses never overlap. Items are handled one at a
// time: a measure, a reset or a partial gather passes the read, magnitude, product and finish
// states; a completed tare adds one 48-step average division, a completed span that division
// and, unless the delta is zero, the scale division, both on the shared bit-serial divider.
// The next item is taken while the previous result still waits in the output register.
module load_cell_tare_span_calibrator import lcal_pkg::*; #(
  parameter int CHANNELS = 4,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic                          cfg_index,
  input  logic [KF_W-1:0]               cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [1:0]                    channel,
  input  logic signed [SAMPLE_BITS-1:0] raw_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    channel_out,
  output logic signed [NORM_W-1:0]      normalized,
  output logic signed [FORCE_W-1:0]     force_res,
  output logic [1:0]                    cal_state,
  output logic [1:0]                    status
);

  localparam int NRM_W = SAMPLE_BITS + 1;
  localparam int SUM_W = SAMPLE_BITS + 16;
  localparam int IDX_W = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
  localparam int DVS_W = NRM_W > CNT_W ? NRM_W : CNT_W;
  localparam int CLP_W = NRM_W > NORM_W ? NRM_W : NORM_W;
  localparam int HI_W  = NRM_W + 24;

  typedef struct packed {
    logic [1:0]                kind;
    logic [CNT_W-1:0]          gathered;
    logic signed [SUM_W-1:0]   sum;
    logic [1:0]                cstate;
    logic signed [SCALE_W-1:0] scale;
    logic signed [SAMPLE_BITS-1:0] offset;
  } rec_t;

  localparam rec_t REC_RESET = '{kind: KIND_NONE, gathered: '0, sum: '0, cstate: ST_UNCAL,
                                 scale: SCALE_ONE, offset: '0};

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_MAG  = 4'd2;
  localparam logic [3:0] S_MHI  = 4'd3;
  localparam logic [3:0] S_MLO  = 4'd4;
  localparam logic [3:0] S_FIN  = 4'd5;
  localparam logic [3:0] S_AVG  = 4'd6;
  localparam logic [3:0] S_SCL  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  // configuration registers
  logic [CNT_W-1:0]       average_count;
  logic signed [KF_W-1:0] known_force;
  logic [CNT_W-1:0]       cnt_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_count <= CNT_W'(1);
      known_force   <= KF_W'(65536);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_AVERAGE_COUNT: average_count <= cfg_data[CNT_W-1:0];
        REG_KNOWN_FORCE:   known_force   <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero count behaves as one
  assign cnt_eff = (average_count == '0) ? CNT_W'(1) : average_count;

  // item registers
  logic [1:0]                    cmd_q;
  logic [1:0]                    ch_q;
  logic [IDX_W-1:0]              idx_q;
  logic signed [SAMPLE_BITS-1:0] raw_q;
  rec_t                          rec;
  logic signed [NRM_W-1:0]       norm_q;
  logic [NRM_W-1:0]              un_q;
  logic [SCALE_W-1:0]            us_q;
  logic                          neg_q;
  logic [HI_W-1:0]               hi_q;
  logic [HI_W-1:0]               lo_q;
  logic signed [FORCE_W-1:0]     force_q;
  logic [1:0]                    stat_q;
  logic [1:0]                    cst_q;
  logic                          sum_neg_q;
  logic                          sneg_q;

  // record memory
  logic             wr_en;
  logic             wr_en_next;
  rec_t             wr_rec;
  logic [IDX_W-1:0] rd_idx;
  logic [$bits(rec_t)-1:0] rd_data;
  rec_t             rd_rec;
  logic             accept;
  logic             ch_ok;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign ch_ok    = (32'(channel) < 32'(CHANNELS));
  assign rd_idx   = IDX_W'(channel);
  assign rd_rec   = rec_t'(rd_data);

  lcal_store #(
    .DEPTH(CHANNELS),
    .DATA_W($bits(rec_t)),
    .ADDR_W(IDX_W),
    .RESET_VAL(REC_RESET)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .we(wr_en),
    .waddr(idx_q),
    .wdata(wr_rec),
    .re(accept),
    .raddr(rd_idx),
    .rdata(rd_data)
  );

  // shared divider for averages and scale
  logic               div_start;
  logic               div_start_next;
  logic [SCALE_W-1:0] div_num;
  logic [DVS_W-1:0]   div_den;
  logic               div_done;
  logic [SCALE_W-1:0] div_quot;

  lcal_div #(
    .NUM_W(SCALE_W),
    .DEN_W(DVS_W)
  ) u_div (
    .clk(clk),
    .rst(rst),
    .start(div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quot(div_quot)
  );

  // force product: hi and lo partial products, truncate, saturate
  logic [63:0]               lim64;
  logic [63:0]               mag64;
  logic [63:0]               magsat;
  logic signed [FORCE_W-1:0] force_c;

  always_comb begin
    lim64   = neg_q ? (64'(MAX48) + 64'd1) : 64'(MAX48);
    mag64   = (64'(hi_q) << 8) + (64'(lo_q) >> 16);
    magsat  = ((64'(hi_q) > (lim64 >> 8)) || (mag64 > lim64)) ? lim64 : mag64;
    force_c = neg_q ? -FORCE_W'(magsat) : FORCE_W'(magsat);
  end

  // gather step: restart when the other kind was being gathered
  logic                    fresh;
  logic signed [SUM_W-1:0] gsum;
  logic [CNT_W-1:0]        gcnt;
  logic                    complete;
  logic [SUM_W-1:0]        gmag;
  logic                    gather_cmd;
  logic                    refused;

  always_comb begin
    fresh      = (rec.kind != cmd_q);
    gsum       = (fresh ? '0 : rec.sum) + SUM_W'(raw_q);
    gcnt       = (fresh ? '0 : rec.gathered) + CNT_W'(1);
    complete   = (gcnt >= cnt_eff);
    gmag       = gsum[SUM_W-1] ? SUM_W'(-gsum) : SUM_W'(gsum);
    gather_cmd = (cmd_q == CMD_TARE) || (cmd_q == CMD_SPAN);
    // span needs a tared channel
    refused    = (cmd_q == CMD_SPAN) && (rec.cstate != ST_TARED);
  end

  // average back to signed, then delta against the stored offset
  logic [SCALE_W-1:0]            avg48;
  logic signed [SAMPLE_BITS-1:0] avg_s;
  logic signed [NRM_W-1:0]       delta;
  logic [NRM_W-1:0]              dmag;
  logic [KF_W-1:0]               kmag;
  logic [SCALE_W-1:0]            scale_c;

  always_comb begin
    avg48   = sum_neg_q ? -div_quot : div_quot;
    avg_s   = avg48[SAMPLE_BITS-1:0];
    delta   = NRM_W'(avg_s) - NRM_W'(rec.offset);
    dmag    = delta[NRM_W-1] ? NRM_W'(-delta) : NRM_W'(delta);
    kmag    = known_force[KF_W-1] ? KF_W'(-known_force) : KF_W'(known_force);
    scale_c = sneg_q ? -div_quot : ((div_quot > MAX48) ? MAX48 : div_quot);
  end

  // records written back: gather in progress, gather ended, tare done, span done
  rec_t rec_gat;
  rec_t rec_clr;
  rec_t rec_tare;
  rec_t rec_span;

  always_comb begin
    rec_gat          = rec;
    rec_gat.sum      = gsum;
    rec_gat.gathered = gcnt;
    rec_gat.kind     = cmd_q;
    rec_clr          = rec;
    rec_clr.sum      = '0;
    rec_clr.gathered = '0;
    rec_clr.kind     = KIND_NONE;
    rec_tare         = rec_clr;
    rec_tare.offset  = avg_s;
    rec_tare.cstate  = ST_TARED;
    rec_span         = rec_clr;
    rec_span.scale   = scale_c;
    rec_span.cstate  = ST_CALIB;
  end

  // output clamp of normalized
  logic signed [CLP_W-1:0] nx;
  logic signed [NORM_W-1:0] norm_out;

  always_comb begin
    nx = CLP_W'(norm_q);
    if (nx > CLP_W'(NORM_LIM)) begin
      norm_out = NORM_W'(NORM_LIM);
    end else if (nx < -CLP_W'(NORM_LIM)) begin
      norm_out = -NORM_W'(NORM_LIM);
    end else begin
      norm_out = NORM_W'(nx);
    end
  end

  logic out_load;
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  // sequencing, write-back and divider launch
  always_comb begin
    state_next     = state;
    wr_en_next     = 1'b0;
    div_start_next = 1'b0;
    unique case (state)
      S_IDLE: begin
        // out of range channels report zeros and touch nothing
        if (accept) begin
          state_next = ch_ok ? S_RD : S_DONE;
        end
      end
      S_RD:  state_next = S_MAG;
      S_MAG: state_next = S_MHI;
      S_MHI: state_next = S_MLO;
      S_MLO: state_next = S_FIN;
      S_FIN: begin
        state_next = S_DONE;
        if (gather_cmd && !refused) begin
          if (complete) begin
            div_start_next = 1'b1;
            state_next     = S_AVG;
          end else begin
            wr_en_next = 1'b1;
          end
        end else if (cmd_q == CMD_RESET) begin
          wr_en_next = 1'b1;
        end
      end
      S_AVG: begin
        if (div_done) begin
          if (cmd_q == CMD_SPAN && delta != '0) begin
            div_start_next = 1'b1;
            state_next     = S_SCL;
          end else begin
            wr_en_next = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_SCL: begin
        if (div_done) begin
          wr_en_next = 1'b1;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      wr_en     <= 1'b0;
      div_start <= 1'b0;
    end else begin
      state     <= state_next;
      wr_en     <= wr_en_next;
      div_start <= div_start_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_q   <= command;
            ch_q    <= channel;
            idx_q   <= rd_idx;
            raw_q   <= raw_sample;
            norm_q  <= '0;
            force_q <= '0;
            stat_q  <= STAT_OK;
            cst_q   <= ST_UNCAL;
          end
        end
        S_RD: begin
          rec    <= rd_rec;
          norm_q <= NRM_W'(raw_q) - NRM_W'(rd_rec.offset);
        end
        S_MAG: begin
          un_q  <= norm_q[NRM_W-1] ? NRM_W'(-norm_q) : NRM_W'(norm_q);
          us_q  <= rec.scale[SCALE_W-1] ? SCALE_W'(-rec.scale) : SCALE_W'(rec.scale);
          neg_q <= norm_q[NRM_W-1] != rec.scale[SCALE_W-1];
          cst_q <= rec.cstate;
        end
        S_MHI: begin
          hi_q <= HI_W'(un_q) * HI_W'(us_q[47:24]);
        end
        S_MLO: begin
          lo_q <= HI_W'(un_q) * HI_W'(us_q[23:0]);
        end
        S_FIN: begin
          force_q <= force_c;
          if (refused) begin
            stat_q <= STAT_NOT_TARE;
          end else if (gather_cmd && complete) begin
            div_num   <= SCALE_W'(gmag);
            div_den   <= DVS_W'(cnt_eff);
            sum_neg_q <= gsum[SUM_W-1];
          end else if (gather_cmd) begin
            stat_q <= STAT_MORE;
            wr_rec <= rec_gat;
          end else if (cmd_q == CMD_RESET) begin
            wr_rec <= REC_RESET;
            cst_q  <= ST_UNCAL;
          end
        end
        S_AVG: begin
          // gathering ends here in every outcome
          if (div_done) begin
            if (cmd_q == CMD_TARE) begin
              wr_rec <= rec_tare;
              cst_q  <= ST_TARED;
            end else if (delta == '0) begin
              wr_rec <= rec_clr;
              stat_q <= STAT_ZERO;
            end else begin
              div_num <= {kmag, 16'd0};
              div_den <= DVS_W'(dmag);
              sneg_q  <= known_force[KF_W-1] != delta[NRM_W-1];
            end
          end
        end
        S_SCL: begin
          if (div_done) begin
            wr_rec <= rec_span;
            cst_q  <= ST_CALIB;
          end
        end
        S_DONE: begin
          if (out_load) begin
            channel_out <= ch_q;
            normalized  <= norm_out;
            force_res   <= force_q;
            cal_state   <= cst_q;
            status      <= stat_q;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/lcal_store.sv]
// per-channel calibration record memory with reset-valid bits
module lcal_store #(
  parameter int DEPTH = 4,
  parameter int DATA_W = 8,
  parameter int ADDR_W = 2,
  parameter logic [DATA_W-1:0] RESET_VAL = '0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  valid;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= valid[raddr] ? mem[raddr] : RESET_VAL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

endmodule

[rtl/lcal_div.sv]
// restoring unsigned divider, one quotient bit per cycle
module lcal_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quot
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [DEN_W:0]   rem;
  logic [DEN_W-1:0] den_q;
  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W:0]   trial;

  assign trial = {rem[DEN_W-1:0], quot[NUM_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CW'(NUM_W);
        quot  <= num;
        den_q <= den;
        rem   <= '0;
      end else if (busy) begin
        if (trial >= {1'b0, den_q}) begin
          rem  <= trial - {1'b0, den_q};
          quot <= {quot[NUM_W-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/lcal_checker.sv]
// port-level assertions for the calibrator and their binding
module lcal_checker import lcal_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          cfg_write,
  input logic                          cfg_index,
  input logic [KF_W-1:0]               cfg_data,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [1:0]                    command,
  input logic [1:0]                    channel,
  input logic signed [SAMPLE_BITS-1:0] raw_sample,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    channel_out,
  input logic signed [NORM_W-1:0]      normalized,
  input logic signed [FORCE_W-1:0]     force_res,
  input logic [1:0]                    cal_state,
  input logic [1:0]                    status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_res) && $stable(status))
    else $error("result beat changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in work");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_ZERO |-> cal_state == ST_TARED)
    else $error("zero delta left tare state");

  a_refuse: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_NOT_TARE |-> cal_state != ST_TARED)
    else $error("span refused on a tared channel");

endmodule

bind load_cell_tare_span_calibrator lcal_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);
